@@ design/efpd_pkg.sv @@
// shared types and constants for the ellipse five-point distance block
`default_nettype none
package efpd_pkg;

  localparam int NPTS    = 5;
  localparam int PW      = 27;   // test point coordinate width
  localparam int DW      = 28;   // offset from reference center
  localparam int PRW     = 44;   // offset times direction
  localparam int XW      = 31;   // rounded projection
  localparam int AW      = 30;   // projection magnitude
  localparam int NUMW    = 60;   // squared projection, Q.16
  localparam int DENW    = 48;   // squared radius, Q.16
  localparam int QW      = 32;   // Q16.16 quotient
  localparam int DIV_LAT = QW + 1;
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;
  localparam logic [QW-1:0] SAT = '1;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_DIR_X        = 3'd2,
    REG_DIR_Y        = 3'd3,
    REG_RADIUS_MAJOR = 3'd4,
    REG_RADIUS_MINOR = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] test_center_x;
    logic signed [23:0] test_center_y;
    logic signed [15:0] test_dir_x;
    logic signed [15:0] test_dir_y;
    logic [23:0]        test_radius_major;
    logic [23:0]        test_radius_minor;
  } in_word_t;

  typedef struct packed {
    logic [31:0] min_norm_distance;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [DENW-1:0]    rx2;
    logic [DENW-1:0]    ry2;
    logic               rzero;
  } cfg_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
  } pt_t;

  typedef pt_t [NPTS-1:0] pts_t;

endpackage
`default_nettype wire

@@ design/efpd_front.sv @@
// front end: accepts test ellipses and forms their five points
`default_nettype none
module efpd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire efpd_pkg::in_word_t in_word,
  input  wire logic              full,
  output logic                   push,
  output efpd_pkg::pts_t         pts
);
  import efpd_pkg::*;

  logic     fv;
  in_word_t w;
  logic     accept;

  logic signed [40:0] pax, pay, pbx, pby;
  logic signed [40:0] rax, ray, rbx, rby;
  logic signed [PW-1:0] ax, ay, bx, by, cx, cy;

  assign in_stall = fv && full;
  assign accept   = in_valid && !in_stall;
  assign push     = fv && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w <= in_word;
    end
  end

  always_comb begin
    pax = $signed({1'b0, w.test_radius_major}) * w.test_dir_x;
    pay = $signed({1'b0, w.test_radius_major}) * w.test_dir_y;
    pbx = $signed({1'b0, w.test_radius_minor}) * w.test_dir_y;
    pby = $signed({1'b0, w.test_radius_minor}) * w.test_dir_x;
    rax = pax + 41'sd8192;
    ray = pay + 41'sd8192;
    rbx = pbx + 41'sd8192;
    rby = pby + 41'sd8192;
    ax  = rax[40:14];
    ay  = ray[40:14];
    bx  = -rbx[40:14];
    by  = rby[40:14];
    cx  = PW'(w.test_center_x);
    cy  = PW'(w.test_center_y);
    pts[0].x = cx;
    pts[0].y = cy;
    pts[1].x = cx + ax;
    pts[1].y = cy + ay;
    pts[2].x = cx - ax;
    pts[2].y = cy - ay;
    pts[3].x = cx + bx;
    pts[3].y = cy + by;
    pts[4].x = cx - bx;
    pts[4].y = cy - by;
  end

endmodule
`default_nettype wire

@@ design/efpd_queue.sv @@
// short queue of point sets between front and back
`default_nettype none
module efpd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire efpd_pkg::pts_t wdata,
  output logic                full,
  input  wire logic           pop,
  output logic                nonempty,
  output efpd_pkg::pts_t      rdata
);
  import efpd_pkg::*;

  pts_t             mem [QDEPTH];
  logic [QAW-1:0]   wp, rp;
  logic [QAW:0]     cnt;

  assign full     = (cnt == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt != '0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/efpd_div.sv @@
// pipelined restoring divider, one quotient bit per stage, Q16.16 result
`default_nettype none
module efpd_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [efpd_pkg::NUMW-1:0] num,
  input  wire logic [efpd_pkg::DENW-1:0] den,
  output logic [efpd_pkg::QW-1:0]        q,
  output logic                           clip
);
  import efpd_pkg::*;

  logic [DENW-1:0] rem [QW+1];
  logic [15:0]     lo  [QW+1];
  logic [QW-1:0]   qq  [QW+1];
  logic            cl  [QW+1];
  logic            ovf;

  // integer part reaches 65536
  assign ovf = {4'b0, num} >= {den, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      cl[0]  <= ovf;
      rem[0] <= ovf ? '0 : DENW'(num[NUMW-1:16]);
      lo[0]  <= num[15:0];
      qq[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DENW:0] t;
    logic          ge;
    assign t  = {rem[k-1], lo[k-1][15]};
    assign ge = t >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DENW'(t - {1'b0, den}) : t[DENW-1:0];
        lo[k]  <= {lo[k-1][14:0], 1'b0};
        qq[k]  <= {qq[k-1][QW-2:0], ge};
        cl[k]  <= cl[k-1];
      end
    end
  end

  assign q    = qq[QW];
  assign clip = cl[QW];

endmodule
`default_nettype wire

@@ design/efpd_back.sv @@
// back end: projection, normalized terms and minimum over the five points
`default_nettype none
module efpd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire efpd_pkg::cfg_t     cfg,
  input  wire logic               nonempty,
  input  wire efpd_pkg::pts_t     rdata,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output efpd_pkg::out_word_t     out_word
);
  import efpd_pkg::*;

  localparam int LAT = 4 + DIV_LAT + 3;

  typedef struct packed {
    logic [QW-1:0] d;
    logic          c;
  } cand_t;

  function automatic cand_t merge(cand_t a, cand_t b);
    cand_t r;
    if (a.d < b.d) begin
      r = a;
    end else if (b.d < a.d) begin
      r = b;
    end else begin
      r.d = a.d;
      r.c = a.c & b.c;
    end
    return r;
  endfunction

  logic           adv;
  logic [LAT-1:0] vpipe;

  logic signed [DW-1:0]  dx [NPTS];
  logic signed [DW-1:0]  dy [NPTS];
  logic signed [PRW-1:0] m1 [NPTS];
  logic signed [PRW-1:0] m2 [NPTS];
  logic signed [PRW-1:0] m3 [NPTS];
  logic signed [PRW-1:0] m4 [NPTS];
  logic signed [XW-1:0]  px [NPTS];
  logic signed [XW-1:0]  py [NPTS];
  logic [NUMW-1:0]       nx [NPTS];
  logic [NUMW-1:0]       ny [NPTS];
  logic [QW-1:0]         qx [NPTS];
  logic [QW-1:0]         qy [NPTS];
  logic                  cx [NPTS];
  logic                  cy [NPTS];
  cand_t                 cand [NPTS];
  cand_t                 m01, m23, p4;

  assign out_valid = vpipe[LAT-1];
  assign adv       = !(out_valid && out_stall);
  assign pop       = adv && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[LAT-2:0], nonempty};
    end
  end

  for (genvar i = 0; i < NPTS; i++) begin : g_lane
    logic signed [PRW:0] sx, sy;
    logic [AW-1:0]       ax, ay;
    logic [QW:0]         sum;

    assign sx  = (PRW+1)'(m1[i]) + (PRW+1)'(m2[i]) + (PRW+1)'(8192);
    assign sy  = (PRW+1)'(m3[i]) - (PRW+1)'(m4[i]) + (PRW+1)'(8192);
    assign ax  = px[i][XW-1] ? AW'(-px[i]) : AW'(px[i]);
    assign ay  = py[i][XW-1] ? AW'(-py[i]) : AW'(py[i]);
    assign sum = (QW+1)'(qx[i]) + (QW+1)'(qy[i]);

    always_ff @(posedge clk) begin
      if (adv) begin
        dx[i] <= DW'(rdata[i].x) - DW'(cfg.center_x);
        dy[i] <= DW'(rdata[i].y) - DW'(cfg.center_y);
        m1[i] <= dx[i] * cfg.dir_x;
        m2[i] <= dy[i] * cfg.dir_y;
        m3[i] <= dy[i] * cfg.dir_x;
        m4[i] <= dx[i] * cfg.dir_y;
        px[i] <= sx[PRW:14];
        py[i] <= sy[PRW:14];
        nx[i] <= ax * ax;
        ny[i] <= ay * ay;
        if (cx[i] || cy[i] || sum[QW]) begin
          cand[i].d <= SAT;
          cand[i].c <= 1'b1;
        end else begin
          cand[i].d <= sum[QW-1:0];
          cand[i].c <= 1'b0;
        end
      end
    end

    efpd_div u_div_x (
      .clk (clk), .en (adv), .num (nx[i]), .den (cfg.rx2), .q (qx[i]), .clip (cx[i])
    );
    efpd_div u_div_y (
      .clk (clk), .en (adv), .num (ny[i]), .den (cfg.ry2), .q (qy[i]), .clip (cy[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m01 <= merge(cand[0], cand[1]);
      m23 <= merge(cand[2], cand[3]);
      p4  <= cand[4];
    end
  end

  always_ff @(posedge clk) begin
    cand_t fin;
    fin = merge(merge(m01, m23), p4);
    if (adv) begin
      if (cfg.rzero) begin
        out_word.min_norm_distance <= SAT;
        out_word.saturated         <= 1'b1;
      end else begin
        out_word.min_norm_distance <= fin.d;
        out_word.saturated         <= fin.c;
      end
    end
  end

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(cfg.rzero) && $past(adv) |->
      out_word.saturated && (out_word.min_norm_distance == SAT))
    else $error("zero radius word not saturated");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe))
    else $error("pipeline moved while stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    vpipe[0] && adv |=> vpipe[1])
    else $error("word lost in pipeline");

endmodule
`default_nettype wire

@@ design/ellipse_five_point_distance.sv @@
// top level: configuration registers, front end, queue and back end
// Takes one test ellipse per cycle while the queue is not full and
// returns one word per ellipse, in order, through one front stage, the
// queue, four projection and squaring stages, the 33-stage restoring
// divider (an input stage, then one quotient bit per stage, ten in
// parallel) and three stages for the sum and the minimum. Throughput is
// one word per cycle while the output side does not stall. Reference
// radii are squared in a register in the cycle after they are written.
`default_nettype none
module ellipse_five_point_distance (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire efpd_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output efpd_pkg::out_word_t      out_word,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);
  import efpd_pkg::*;

  logic signed [23:0] center_x, center_y;
  logic signed [15:0] dir_x, dir_y;
  logic [23:0]        radius_major, radius_minor;
  logic [DENW-1:0]    rx2, ry2;
  logic               rzero;
  cfg_t               cfg;
  logic               push, full, pop, nonempty;
  pts_t               wdata, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      dir_x        <= 16'sd16384;
      dir_y        <= '0;
      radius_major <= 24'd256;
      radius_minor <= 24'd256;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_DIR_X:        dir_x        <= cfg_data[15:0];
        REG_DIR_Y:        dir_y        <= cfg_data[15:0];
        REG_RADIUS_MAJOR: radius_major <= cfg_data;
        REG_RADIUS_MINOR: radius_minor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rx2   <= radius_major * radius_major;
    ry2   <= radius_minor * radius_minor;
    rzero <= (radius_major == '0) || (radius_minor == '0);
  end

  assign cfg = '{center_x: center_x, center_y: center_y, dir_x: dir_x, dir_y: dir_y,
                 rx2: rx2, ry2: ry2, rzero: rzero};

  efpd_front u_front (
    .clk (clk), .rst (rst), .in_valid (in_valid), .in_stall (in_stall),
    .in_word (in_word), .full (full), .push (push), .pts (wdata)
  );

  efpd_queue u_queue (
    .clk (clk), .rst (rst), .push (push), .wdata (wdata), .full (full),
    .pop (pop), .nonempty (nonempty), .rdata (rdata)
  );

  efpd_back u_back (
    .clk (clk), .rst (rst), .cfg (cfg), .nonempty (nonempty), .rdata (rdata),
    .pop (pop), .out_valid (out_valid), .out_stall (out_stall), .out_word (out_word)
  );

endmodule
`default_nettype wire
